### hdl/i2cmts_pkg.sv
// Package for the I2C master transaction sequencer.
// Holds the command and phase codes, the expected bus status codes and the result type.
// No dependencies.
package i2cmts_pkg;

  localparam int unsigned OpWidth    = 1;
  localparam int unsigned InDataBits = 48;
  localparam int unsigned OutDataBits = 24;
  localparam int unsigned CmdWidth   = 3;

  localparam logic [7:0] AddrMask = 8'hf0;

  // Bus engine status codes expected after each command
  localparam logic [7:0] StSlawAck   = 8'h18;
  localparam logic [7:0] StDataAck   = 8'h28;
  localparam logic [7:0] StRepStart  = 8'h10;
  localparam logic [7:0] StSlarAck   = 8'h40;
  localparam logic [7:0] StRdataAck  = 8'h50;
  localparam logic [7:0] StRdataNack = 8'h58;

  typedef enum logic [OpWidth-1:0] {
    OP_BEGIN    = 1'b0,
    OP_BUS_DONE = 1'b1
  } op_e;

  typedef enum logic [CmdWidth-1:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_SEND      = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_SLAW  = 4'd2,
    PH_DATA  = 4'd3,
    PH_REP   = 4'd4,
    PH_SLAR  = 4'd5,
    PH_RACK  = 4'd6,
    PH_RNACK = 4'd7
  } phase_e;

  typedef struct packed {
    logic       failed;
    logic       finished;
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] send_data;
    cmd_e       command;
  } res_t;

endpackage

### hdl/i2c_master_transaction_sequencer_unit.sv
// Top level of the I2C master transaction sequencer.
// Depends on i2cmts_pkg for codes and the result type.
//
//  channel  | dir | tdata                                       | tuser
//  s_axis   | in  | address, write_count, read_count,           | operation
//           |     | bus_status, rx_byte, tx_byte (48 bits)      |
//  m_axis   | out | send_data, read_valid, read_data, finished, | command
//           |     | failed, 5 zero bits (24 bits)               |
//
// One item in, one result out, one item per cycle sustained while m_axis is not stalled.
// Each item passes through an input register, then one state step into the result register.
// Both registers advance together when the result register is empty or being taken,
// so a stall on m_axis holds both stages and back-pressures s_axis after two items.
// Reset clears the phase, counters and both valid flags.
module i2c_master_transaction_sequencer_unit
  import i2cmts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // address, write_count, read_count, bus_status, rx_byte, tx_byte
  input  logic [InDataBits-1:0]  s_axis_tdata_i,
  // operation
  input  logic [OpWidth-1:0]     s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // send_data, read_valid, read_data, finished, failed, zero fill
  output logic [OutDataBits-1:0] m_axis_tdata_o,
  // command
  output logic [CmdWidth-1:0]    m_axis_tuser_o
);

  logic                  in_vld_q;
  logic [InDataBits-1:0] in_data_q;
  op_e                   in_op_q;
  logic                  out_vld_q;
  res_t                  res_q, res_d;

  phase_e     phase_q, phase_d;
  logic [7:0] writes_left_q, writes_left_d;
  logic [7:0] reads_left_q, reads_left_d;
  logic [7:0] slave_byte_q, slave_byte_d;
  logic       read_wanted_q, read_wanted_d;

  logic       advance;
  logic       step;
  logic [7:0] address, write_count, read_count, bus_status, rx_byte, tx_byte;

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;

  assign address     = in_data_q[7:0];
  assign write_count = in_data_q[15:8];
  assign read_count  = in_data_q[23:16];
  assign bus_status  = in_data_q[31:24];
  assign rx_byte     = in_data_q[39:32];
  assign tx_byte     = in_data_q[47:40];

  always_comb begin
    res_d         = '0;
    res_d.command = CMD_NONE;
    phase_d       = phase_q;
    writes_left_d = writes_left_q;
    reads_left_d  = reads_left_q;
    slave_byte_d  = slave_byte_q;
    read_wanted_d = read_wanted_q;

    if (in_op_q == OP_BEGIN) begin
      // Drop any running transaction and start afresh
      slave_byte_d  = address;
      writes_left_d = write_count;
      reads_left_d  = read_count;
      read_wanted_d = (read_count != 8'd0);
      res_d.command = CMD_START;
      phase_d       = PH_START;
    end else begin
      unique case (phase_q)
        PH_START: begin
          res_d.command   = CMD_SEND;
          res_d.send_data = slave_byte_q & AddrMask;
          phase_d         = PH_SLAW;
        end
        PH_SLAW, PH_DATA: begin
          if ((phase_q == PH_SLAW && bus_status != StSlawAck) ||
              (phase_q == PH_DATA && bus_status != StDataAck)) begin
            res_d.command  = CMD_STOP;
            res_d.finished = 1'b1;
            res_d.failed   = 1'b1;
            phase_d        = PH_IDLE;
          end else if (writes_left_q != 8'd0) begin
            res_d.command   = CMD_SEND;
            res_d.send_data = tx_byte;
            writes_left_d   = writes_left_q - 8'd1;
            phase_d         = PH_DATA;
          end else if (read_wanted_q) begin
            res_d.command = CMD_START;
            phase_d       = PH_REP;
          end else begin
            res_d.command  = CMD_STOP;
            res_d.finished = 1'b1;
            phase_d        = PH_IDLE;
          end
        end
        PH_REP: begin
          if (bus_status != StRepStart) begin
            res_d.command  = CMD_STOP;
            res_d.finished = 1'b1;
            res_d.failed   = 1'b1;
            phase_d        = PH_IDLE;
          end else begin
            res_d.command   = CMD_SEND;
            res_d.send_data = (slave_byte_q & AddrMask) | 8'h01;
            phase_d         = PH_SLAR;
          end
        end
        PH_SLAR, PH_RACK: begin
          if (phase_q == PH_RACK) begin
            res_d.read_valid = 1'b1;
            res_d.read_data  = rx_byte;
          end
          if ((phase_q == PH_SLAR && bus_status != StSlarAck) ||
              (phase_q == PH_RACK && bus_status != StRdataAck)) begin
            res_d.command  = CMD_STOP;
            res_d.finished = 1'b1;
            res_d.failed   = 1'b1;
            phase_d        = PH_IDLE;
          end else if (reads_left_q > 8'd1) begin
            res_d.command = CMD_READ_ACK;
            reads_left_d  = reads_left_q - 8'd1;
            phase_d       = PH_RACK;
          end else begin
            res_d.command = CMD_READ_NACK;
            phase_d       = PH_RNACK;
          end
        end
        PH_RNACK: begin
          res_d.read_valid = 1'b1;
          res_d.read_data  = rx_byte;
          res_d.command    = CMD_STOP;
          res_d.finished   = 1'b1;
          res_d.failed     = (bus_status != StRdataNack);
          phase_d          = PH_IDLE;
        end
        default: begin
          // Bus done while idle: ignore
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      phase_q       <= PH_IDLE;
      writes_left_q <= '0;
      reads_left_q  <= '0;
      slave_byte_q  <= '0;
      read_wanted_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (step) begin
        phase_q       <= phase_d;
        writes_left_q <= writes_left_d;
        reads_left_q  <= reads_left_d;
        slave_byte_q  <= slave_byte_d;
        read_wanted_q <= read_wanted_d;
      end
    end
  end

  // Payload registers: load on transfer only
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
      in_op_q   <= op_e'(s_axis_tuser_i);
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_q.command;
  assign m_axis_tdata_o  = {5'b0, res_q.failed, res_q.finished, res_q.read_data,
                            res_q.read_valid, res_q.send_data};

endmodule

### hdl/i2cmts_checker.sv
// Port-level checks for the I2C master transaction sequencer.
// Depends on i2cmts_pkg; bound to i2c_master_transaction_sequencer_unit below.
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OutDataBits-1:0] m_axis_tdata_o,
  input logic [CmdWidth-1:0]    m_axis_tuser_o
);

  // A failed transaction always ends with a finishing STOP
  a_fail_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[18]) |->
      (m_axis_tdata_o[17] && m_axis_tuser_o == CMD_STOP))
    else $error("failed without finishing STOP");

  a_finish_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[17]) |-> (m_axis_tuser_o == CMD_STOP))
    else $error("finished on a command other than STOP");

  a_send_data_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != CMD_SEND) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("send data present without a send command");

  a_read_with_read_or_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[8]) |->
      (m_axis_tuser_o == CMD_STOP || m_axis_tuser_o == CMD_READ_ACK ||
       m_axis_tuser_o == CMD_READ_NACK))
    else $error("received byte alongside an unrelated command");

  // Hold the result while the sink stalls
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result changed during stall");

endmodule

bind i2c_master_transaction_sequencer_unit i2cmts_checker u_i2cmts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
